[rtl/core/nth_weekday_date_finder_core_defines.svh]
`ifndef NTH_WEEKDAY_DATE_FINDER_CORE_DEFINES_SVH
`define NTH_WEEKDAY_DATE_FINDER_CORE_DEFINES_SVH

// same-cycle check, held off while reset is active
`define NWDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nwdf same-cycle check failed");

// next-cycle check, held off while reset is active
`define NWDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nwdf next-cycle check failed");

`endif

[rtl/core/nwdf_pkg.sv]
package nwdf_pkg;

    localparam int STAGES = 6;

    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;

    function automatic logic [8:0] f_month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'(leap && (m >= 4'd2));
    endfunction

endpackage

[rtl/core/nth_weekday_date_finder_core.sv]
// Finds the month and day of the n-th given weekday (0 Sunday .. 6 Saturday)
// of a Gregorian year. Six register stages; one item is taken every cycle
// while o_stall is low. Each stage holds its item until the next stage frees,
// so bubbles close up and input keeps flowing while a finished result waits at
// the output. o_stall rises only when all six stages are full and the output
// is stalled. date_valid is 0 (with month and day_of_month 0) for year 0,
// weekday 7, occurrence 0, or a date past December 31.
`include "nth_weekday_date_finder_core_defines.svh"

module nth_weekday_date_finder_core
    import nwdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_year,
    input  logic [2:0]  i_weekday,
    input  logic [5:0]  i_occurrence,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic        o_date_valid
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;

    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: prior year and divisions by 100
    logic [11:0] n_prev;
    logic [24:0] n_prod_prev;
    logic [24:0] n_prod_year;
    logic [11:0] r1_prev;
    logic [5:0]  r1_q100;
    logic [11:0] r1_year;
    logic [5:0]  r1_yq100;
    logic [2:0]  r1_wday;
    logic [5:0]  r1_occ;
    logic        r1_ok;

    always_comb begin
        n_prev      = i_year - 12'd1;
        n_prod_prev = 25'(n_prev) * 25'(RECIP_100);
        n_prod_year = 25'(i_year) * 25'(RECIP_100);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_prev  <= n_prev;
            r1_q100  <= n_prod_prev[RECIP_SHIFT +: 6];
            r1_year  <= i_year;
            r1_yq100 <= n_prod_year[RECIP_SHIFT +: 6];
            r1_wday  <= i_weekday;
            r1_occ   <= i_occurrence;
            r1_ok    <= (i_year != 12'd0) && (i_weekday != 3'd7) && (i_occurrence != 6'd0);
        end
    end

    // stage 2: day count folded mod 7 (365 = 1 mod 7) and leap test
    logic [12:0] n_sum;
    logic [11:0] n_yr100_w;
    logic [6:0]  n_yr100;
    logic        n_leap;
    logic [12:0] r2_sum;
    logic        r2_leap;
    logic [2:0]  r2_wday;
    logic [5:0]  r2_occ;
    logic        r2_ok;

    always_comb begin
        n_sum = 13'(r1_prev) + 13'(r1_prev >> 2) + 13'(r1_q100 >> 2) - 13'(r1_q100);
        n_yr100_w = r1_year - 12'(r1_yq100) * 12'd100;
        n_yr100 = n_yr100_w[6:0];
        n_leap = (n_yr100 == 7'd0) ? (r1_yq100[1:0] == 2'd0) : (r1_year[1:0] == 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_sum  <= n_sum;
            r2_leap <= n_leap;
            r2_wday <= r1_wday;
            r2_occ  <= r1_occ;
            r2_ok   <= r1_ok;
        end
    end

    // stage 3: mod 7 by summing octal digits (8 = 1 mod 7)
    logic [5:0] n_dsum;
    logic [3:0] n_fold;
    logic [2:0] n_m7;
    logic [2:0] r3_m7;
    logic       r3_leap;
    logic [2:0] r3_wday;
    logic [5:0] r3_occ;
    logic       r3_ok;

    always_comb begin
        n_dsum = 6'(r2_sum[2:0]) + 6'(r2_sum[5:3]) + 6'(r2_sum[8:6])
               + 6'(r2_sum[11:9]) + 6'(r2_sum[12]);
        n_fold = 4'(n_dsum[5:3]) + 4'(n_dsum[2:0]);
        n_m7   = (n_fold >= 4'd7) ? 3'(n_fold - 4'd7) : n_fold[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_m7   <= n_m7;
            r3_leap <= r2_leap;
            r3_wday <= r2_wday;
            r3_occ  <= r2_occ;
            r3_ok   <= r2_ok;
        end
    end

    // stage 4: day of year of the wanted occurrence
    logic [3:0] n_t;
    logic [2:0] n_f;
    logic [5:0] n_occm1;
    logic [8:0] n_doy;
    logic [8:0] r4_doy;
    logic       r4_leap;
    logic       r4_ok;

    always_comb begin
        n_t     = 4'(r3_wday) + 4'd6 - 4'(r3_m7);
        n_f     = (n_t >= 4'd7) ? 3'(n_t - 4'd7) : n_t[2:0];
        n_occm1 = r3_occ - 6'd1;
        n_doy   = 9'(n_f) + 9'd1 + (9'(n_occm1) << 3) - 9'(n_occm1);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_doy  <= n_doy;
            r4_leap <= r3_leap;
            r4_ok   <= r3_ok;
        end
    end

    // stage 5: month lookup and range check
    logic [3:0] w_month;
    logic [8:0] w_start;
    logic [3:0] r5_month;
    logic [8:0] r5_start;
    logic [8:0] r5_doy;
    logic       r5_ok;

    nwdf_month_sel u_month_sel (
        .i_doy   (r4_doy),
        .i_leap  (r4_leap),
        .o_month (w_month),
        .o_start (w_start)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_month <= w_month;
            r5_start <= w_start;
            r5_doy   <= r4_doy;
            r5_ok    <= r4_ok && (r4_doy <= (r4_leap ? DAYS_LEAP : DAYS_COMMON));
        end
    end

    // stage 6: day of month, output register
    logic [8:0] n_dom;
    logic [3:0] r6_month;
    logic [4:0] r6_dom;
    logic       r6_ok;

    assign n_dom = r5_doy - r5_start;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r6_month <= r5_ok ? r5_month : 4'd0;
            r6_dom   <= r5_ok ? n_dom[4:0] : 5'd0;
            r6_ok    <= r5_ok;
        end
    end

    assign o_month        = r6_month;
    assign o_day_of_month = r6_dom;
    assign o_date_valid   = r6_ok;

    `NWDF_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, i_stall && (&r_vld))
    `NWDF_ASSERT_NOW(a_month_in_range, i_clk, i_rst_n, o_valid && o_date_valid,
        (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month != 5'd0))
    `NWDF_ASSERT_NOW(a_invalid_zeroed, i_clk, i_rst_n, o_valid && !o_date_valid,
        (o_month == 4'd0) && (o_day_of_month == 5'd0))

endmodule

[rtl/core/nwdf_month_sel.sv]
module nwdf_month_sel
    import nwdf_pkg::*;
(
    input  logic [8:0] i_doy,
    input  logic       i_leap,
    output logic [3:0] o_month,
    output logic [8:0] o_start
);

    always_comb begin
        o_month = 4'd1;
        o_start = 9'd0;
        for (int m = 1; m < 12; m++) begin
            if (i_doy > f_month_start(4'(m), i_leap)) begin
                o_month = 4'(m + 1);
                o_start = f_month_start(4'(m), i_leap);
            end
        end
    end

endmodule
